/* rtl/ndd_pkg.sv */
// Shared types and constants for the neighbor difference detector.
package ndd_pkg;

  // Fixed field widths of the channels
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned HASH_W    = 64;
  localparam int unsigned SIZE_W    = 12;
  localparam int unsigned CFG_IDX_W = 8;

  // Result queue geometry (power of two, pointers wrap naturally)
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

  // Size register reset values
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

  // Input operation codes
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // What occupies the read-modify-write stage
  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_PIXEL,
    KIND_FLUSH,
    KIND_PRIME
  } kind_e;

  // One result item
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               flag;
    logic               last;
    logic               done;
  } res_item_t;

  // Push request into the result queue: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    res_item_t  first;
    res_item_t  second;
  } res_push_t;

endpackage

/* rtl/ndd_if.sv */
// Channel interfaces: pixel input, result output and configuration write.
interface ndd_in_if;
  import ndd_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [HASH_W-1:0] hash_value;
  modport source (output valid, output operation, output hash_value, input ready);
  modport sink (input valid, input operation, input hash_value, output ready);
endinterface

interface ndd_out_if;
  import ndd_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] pixel_column;
  logic               needs_resample;
  logic               last_in_run;
  logic               frame_done;
  modport source (output valid, output pixel_row, output pixel_column,
                  output needs_resample, output last_in_run, output frame_done,
                  input ready);
  modport sink (input valid, input pixel_row, input pixel_column,
                input needs_resample, input last_in_run, input frame_done,
                output ready);
endinterface

interface ndd_cfg_if;
  import ndd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/ndd_res_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transfer.
module ndd_res_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ndd_pkg::res_push_t                push_i,
  output logic [ndd_pkg::RES_CNT_W-1:0]     level_o,
  ndd_out_if.source                         res_o
);
  import ndd_pkg::*;

  res_item_t              entry_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [RES_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   pop;
  res_item_t              head;

  // Head of queue drives the output channel
  assign head                 = entry_q[rd_ptr_q];
  assign res_o.valid          = (cnt_q != '0);
  assign res_o.pixel_row      = head.row;
  assign res_o.pixel_column   = head.col;
  assign res_o.needs_resample = head.flag;
  assign res_o.last_in_run    = head.last;
  assign res_o.frame_done     = head.done;
  assign pop                  = res_o.valid && res_o.ready;
  assign level_o              = cnt_q;
  assign wr_ptr_nx            = wr_ptr_q + RES_PTR_W'(1);

  // Pointer and level update
  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + RES_PTR_W'(pop);
    cnt_d    = cnt_q + RES_CNT_W'(push_i.count) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, second result lands one slot after the first
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entry_q[wr_ptr_nx] <= push_i.second;
    end
  end

  // Upstream credit check must keep every push within the free space
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (int'(cnt_q) + int'(push_i.count) <= int'(RES_DEPTH)))
    else $error("result queue overflow");

  a_no_triple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd3)
    else $error("more than two results pushed in one cycle");

  a_level_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd0 && !pop) |=> $stable(cnt_q))
    else $error("queue level moved without push or pop");

endmodule

/* rtl/neighbor_difference_detector.sv */
// Top level: 3x3 neighbor hash difference detector over raster-order frames.
// Path: a transfer goes through the read-modify-write stage, its results into the queue.
// Throughput: one input item per cycle when the queue has room (single store read port);
// input is held off after the frame's last pixel while column 0 is read ahead for flush.
// Output: one result per cycle unless stalled; a row-end pixel can yield two; 8-entry queue.
// Reset: position, drain state and queue clear, sizes go to 640x480; line stores not cleared.
module neighbor_difference_detector #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  parameter int unsigned HASH_BITS  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ndd_in_if.sink     pix_i,
  ndd_out_if.source  res_o,
  ndd_cfg_if.sink    cfg_i
);
  import ndd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // Configuration
  logic [SIZE_W-1:0]    frame_width_q, frame_width_d, frame_height_q, frame_height_d;
  logic                 cfg_we, cfg_hit;
  logic [CW-1:0]        last_col;
  logic [RW-1:0]        last_row;

  // Input position and drain control
  logic [RW-1:0]        row_q, row_d;
  logic [CW-1:0]        col_q, col_d, fcol_q, fcol_d;
  logic                 draining_q, draining_d, prime_q, prime_d;
  logic                 accept, credit_ok, do_pixel, do_flush;
  logic [RES_CNT_W-1:0] level;

  // Line stores
  logic [HASH_BITS-1:0] upper_mem  [MAX_WIDTH];
  logic [HASH_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [CW-1:0]        rd_addr;
  logic [HASH_BITS-1:0] up_rd_q, mid_rd_q, up_cur, mid_cur;
  logic                 mem_we;

  // Read-modify-write stage
  kind_e                s1_kind_q, s1_kind_d;
  logic [RW-1:0]        s1_row_q;
  logic [CW-1:0]        s1_col_q;
  logic [HASH_BITS-1:0] s1_hash_q;
  logic                 s1_fwd_q, s1_fwd_d;
  logic [HASH_BITS-1:0] fwd_up_q, fwd_mid_q;

  // Pixel window [row][col] and flush window (left, center, right)
  logic [HASH_BITS-1:0] win_q  [3][3];
  logic [HASH_BITS-1:0] fup_q  [3];
  logic [HASH_BITS-1:0] fmid_q [3];

  // Result computation
  logic                 r_ge2, c_ge1, c_ge2, emit_a, emit_b;
  logic                 flag_a, flag_b;
  logic [HASH_BITS-1:0] ca, cb, fc;
  logic                 f_lv, f_rv, f_h2, f_flag;
  res_item_t            res_a, res_b, res_f;
  res_push_t            push;

  // ---------------------------------------------------------------------------
  // Configuration port and effective sizes
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    cfg_hit        = 1'b0;
    if (cfg_we) begin
      unique case (cfg_i.index)
        CFG_FRAME_WIDTH: begin
          frame_width_d = cfg_i.wdata;
          cfg_hit       = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height_d = cfg_i.wdata;
          cfg_hit        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // Clamp sizes to 1..MAX, kept as last index
  always_comb begin
    if (frame_width_q == '0) begin
      last_col = '0;
    end else if (int'(frame_width_q) > int'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(int'(frame_width_q) - 1);
    end
    if (frame_height_q == '0) begin
      last_row = '0;
    end else if (int'(frame_height_q) > int'(MAX_HEIGHT)) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(int'(frame_height_q) - 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Input handshake: room for two results per item in flight
  assign credit_ok = (int'(level) + ((s1_kind_q != KIND_IDLE) ? 2 : 0) + 2)
                     <= int'(RES_DEPTH);
  assign pix_i.ready = credit_ok && !prime_q;
  assign accept      = pix_i.valid && pix_i.ready;
  assign do_pixel    = accept && (pix_i.operation == OP_PIXEL) && !draining_q;
  assign do_flush    = accept && (pix_i.operation == OP_FLUSH) && draining_q;

  // Raster position, flush column and drain state
  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    fcol_d     = fcol_q;
    draining_d = draining_q;
    prime_d    = 1'b0;
    if (cfg_hit) begin
      row_d      = '0;
      col_d      = '0;
      fcol_d     = '0;
      draining_d = 1'b0;
    end else if (do_pixel) begin
      if (col_q != last_col) begin
        col_d = col_q + CW'(1);
      end else begin
        col_d = '0;
        if (row_q != last_row) begin
          row_d = row_q + RW'(1);
        end else begin
          row_d      = '0;
          draining_d = 1'b1;
          fcol_d     = '0;
          prime_d    = 1'b1;
        end
      end
    end else if (do_flush) begin
      if (fcol_q != last_col) begin
        fcol_d = fcol_q + CW'(1);
      end else begin
        fcol_d     = '0;
        draining_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      fcol_q     <= '0;
      draining_q <= 1'b0;
      prime_q    <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      fcol_q     <= fcol_d;
      draining_q <= draining_d;
      prime_q    <= prime_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Read address: flush reads one column ahead, prime fetches column 0
  always_comb begin
    if (prime_q) begin
      rd_addr = '0;
    end else if (draining_q) begin
      rd_addr = (fcol_q == last_col) ? fcol_q : fcol_q + CW'(1);
    end else begin
      rd_addr = col_q;
    end
  end

  // Stage tag and bypass when the stage ahead writes the column being read
  always_comb begin
    if (prime_q) begin
      s1_kind_d = KIND_PRIME;
    end else if (do_pixel) begin
      s1_kind_d = KIND_PIXEL;
    end else if (do_flush) begin
      s1_kind_d = KIND_FLUSH;
    end else begin
      s1_kind_d = KIND_IDLE;
    end
    s1_fwd_d = (s1_kind_q == KIND_PIXEL) && (s1_col_q == rd_addr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_kind_q <= KIND_IDLE;
      s1_fwd_q  <= 1'b0;
    end else begin
      s1_kind_q <= s1_kind_d;
      s1_fwd_q  <= s1_fwd_d;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    s1_row_q  <= row_q;
    s1_col_q  <= draining_q ? fcol_q : col_q;
    s1_hash_q <= pix_i.hash_value[HASH_BITS-1:0];
    fwd_up_q  <= mid_cur;
    fwd_mid_q <= s1_hash_q;
  end

  // ---------------------------------------------------------------------------
  // Line stores: read-first, upper takes the old middle, middle takes the new hash
  assign mem_we  = (s1_kind_q == KIND_PIXEL);
  assign up_cur  = s1_fwd_q ? fwd_up_q  : up_rd_q;
  assign mid_cur = s1_fwd_q ? fwd_mid_q : mid_rd_q;

  always_ff @(posedge clk_i) begin
    up_rd_q <= upper_mem[rd_addr];
    if (mem_we) begin
      upper_mem[s1_col_q] <= mid_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_rd_q <= middle_mem[rd_addr];
    if (mem_we) begin
      middle_mem[s1_col_q] <= s1_hash_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Window shifts
  always_ff @(posedge clk_i) begin
    if (s1_kind_q == KIND_PIXEL) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= up_cur;
      win_q[1][2] <= mid_cur;
      win_q[2][2] <= s1_hash_q;
    end
    if (s1_kind_q == KIND_FLUSH || s1_kind_q == KIND_PRIME) begin
      fup_q[0]  <= fup_q[1];
      fup_q[1]  <= fup_q[2];
      fup_q[2]  <= up_cur;
      fmid_q[0] <= fmid_q[1];
      fmid_q[1] <= fmid_q[2];
      fmid_q[2] <= mid_cur;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel flags, taken on the window as it looks after the shift
  assign r_ge2  = (s1_row_q >= RW'(2));
  assign c_ge1  = (s1_col_q != '0);
  assign c_ge2  = (s1_col_q >= CW'(2));
  assign emit_a = (s1_row_q != '0) && c_ge1;
  assign emit_b = (s1_row_q != '0) && (s1_col_q == last_col);
  assign ca     = win_q[1][2];
  assign cb     = mid_cur;

  // Center one column back
  assign flag_a = (r_ge2 && ((c_ge2 && win_q[0][1] != ca) || win_q[0][2] != ca || up_cur != ca))
                || (c_ge2 && win_q[1][1] != ca) || (mid_cur != ca)
                || (c_ge2 && win_q[2][1] != ca) || (win_q[2][2] != ca) || (s1_hash_q != ca);

  // Center in the newest column (row end)
  assign flag_b = (r_ge2 && ((c_ge1 && win_q[0][2] != cb) || up_cur != cb))
                || (c_ge1 && (win_q[1][2] != cb || win_q[2][2] != cb))
                || (s1_hash_q != cb);

  // Flush flag over the last row and the row above it
  assign f_lv   = (s1_col_q != '0);
  assign f_rv   = (s1_col_q != last_col);
  assign f_h2   = (last_row != '0);
  assign fc     = fmid_q[2];
  assign f_flag = (f_lv && fmid_q[1] != fc) || (f_rv && mid_cur != fc)
                || (f_h2 && ((f_lv && fup_q[1] != fc) || fup_q[2] != fc
                             || (f_rv && up_cur != fc)));

  // Result items
  always_comb begin
    res_a.row  = COORD_W'(s1_row_q - RW'(1));
    res_a.col  = COORD_W'(s1_col_q - CW'(1));
    res_a.flag = flag_a;
    res_a.last = !emit_b;
    res_a.done = 1'b0;
    res_b.row  = COORD_W'(s1_row_q - RW'(1));
    res_b.col  = COORD_W'(s1_col_q);
    res_b.flag = flag_b;
    res_b.last = 1'b1;
    res_b.done = 1'b0;
    res_f.row  = COORD_W'(last_row);
    res_f.col  = COORD_W'(s1_col_q);
    res_f.flag = f_flag;
    res_f.last = 1'b1;
    res_f.done = (s1_col_q == last_col);
  end

  // Push into the result queue
  always_comb begin
    push.count  = 2'd0;
    push.first  = res_a;
    push.second = res_b;
    case (s1_kind_q)
      KIND_PIXEL: begin
        if (emit_a && emit_b) begin
          push.count = 2'd2;
        end else if (emit_a) begin
          push.count = 2'd1;
        end else if (emit_b) begin
          push.count = 2'd1;
          push.first = res_b;
        end
      end
      KIND_FLUSH: begin
        push.count = 2'd1;
        push.first = res_f;
      end
      default: ;
    endcase
  end

  ndd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .level_o (level),
    .res_o   (res_o)
  );

  // ---------------------------------------------------------------------------
  a_prime_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prime_q |-> !(pix_i.valid && pix_i.ready))
    else $error("input transfer during column 0 read-ahead");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> $past(s1_kind_q == KIND_PIXEL))
    else $error("bypass taken without a preceding store write");

  a_position_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= last_row) && (col_q <= last_col) && (fcol_q <= last_col))
    else $error("raster or flush position outside the frame");

endmodule

/* tb/sv/neighbor_difference_detector_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the neighbor difference detector, with a built-in flag predictor.
module neighbor_difference_detector_tb;
  import ndd_pkg::*;

  localparam int unsigned MAX_W        = 2048;
  localparam int unsigned MAX_H        = 2048;
  localparam int unsigned HASH_BITS    = 64;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned NO_CUT       = 32'hFFFF_FFFF;
  localparam logic [HASH_W-1:0] HASH_MASK =
    (HASH_BITS >= HASH_W) ? {HASH_W{1'b1}} : ((64'd1 << HASH_BITS) - 64'd1);
  // Index that maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  ndd_in_if  pix_if ();
  ndd_out_if res_if ();
  ndd_cfg_if cfg_if ();

  neighbor_difference_detector #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .HASH_BITS  (HASH_BITS)
  ) DUT (
    .clk_i,
    .rst_ni,
    .pix_i (pix_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Predictor state: line stores, 3x3 window, raster position, drain pass
  bit [HASH_W-1:0]   upper_row_hash  [MAX_W];
  bit [HASH_W-1:0]   middle_row_hash [MAX_W];
  bit [HASH_W-1:0]   window_hash     [9];
  logic [SIZE_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [SIZE_W-1:0] height_reg = FRAME_HEIGHT_RST;
  int unsigned       in_row;
  int unsigned       in_col;
  int unsigned       drain_col;
  bit                draining;

  res_item_t         expected_flags [$];
  int unsigned       mismatch_count;
  int unsigned       send_gap_pct;
  int unsigned       stall_pct;
  bit [HASH_W-1:0]   palette [4];
  int unsigned       gap_by_phase   [4] = '{0, 80, 0, 38};
  int unsigned       stall_by_phase [4] = '{0, 0, 80, 38};

  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned max_size);
    if (v == '0) return 1;
    if (v > max_size) return max_size;
    return 32'(v);
  endfunction

  // A write to a mapped register restarts the frame
  function automatic void load_size_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    if (idx == CFG_FRAME_WIDTH) width_reg = data;
    else if (idx == CFG_FRAME_HEIGHT) height_reg = data;
    else return;
    in_row    = 0;
    in_col    = 0;
    drain_col = 0;
    draining  = 1'b0;
  endfunction

  function automatic res_item_t flag_item(int unsigned row, int unsigned col, bit flag,
                                          bit last, bit done);
    res_item_t item;
    item.row  = row[COORD_W-1:0];
    item.col  = col[COORD_W-1:0];
    item.flag = flag;
    item.last = last;
    item.done = done;
    return item;
  endfunction

  // Window center sits in row 1, column cc; rows_ok/cols_ok mask out-of-frame cells
  function automatic bit window_differs(int cc, bit [2:0] rows_ok, bit [2:0] cols_ok);
    bit [HASH_W-1:0] center;
    center = window_hash[3 + cc];
    for (int dr = 0; dr < 3; dr++) begin
      for (int col = cc - 1; col <= cc + 1; col++) begin
        if (!rows_ok[dr] || col < 0 || col > 2) continue;
        if (!cols_ok[col] || (dr == 1 && col == cc)) continue;
        if (window_hash[dr * 3 + col] != center) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Pixel transfer: shift the window, update line stores, emit 0..2 flags
  function automatic void push_pixel_flags(logic [HASH_W-1:0] raw);
    int unsigned     w;
    int unsigned     h;
    int unsigned     r;
    int unsigned     c;
    int unsigned     n;
    bit [HASH_W-1:0] hash;
    res_item_t       run [2];
    bit [2:0]        rows_ok;
    bit [2:0]        cols_ok;
    if (draining) return;
    w    = clamp_size(width_reg, MAX_W);
    h    = clamp_size(height_reg, MAX_H);
    r    = in_row;
    c    = in_col;
    n    = 0;
    hash = raw & HASH_MASK;
    if (c >= w || r >= h) begin
      r = 0;
      c = 0;
    end
    for (int i = 0; i < 3; i++) begin
      window_hash[i * 3]     = window_hash[i * 3 + 1];
      window_hash[i * 3 + 1] = window_hash[i * 3 + 2];
    end
    window_hash[2]     = upper_row_hash[c];
    window_hash[5]     = middle_row_hash[c];
    window_hash[8]     = hash;
    upper_row_hash[c]  = middle_row_hash[c];
    middle_row_hash[c] = hash;
    rows_ok = {1'b1, 1'b1, r >= 2};
    cols_ok = {1'b1, c >= 1, c >= 2};
    if (r >= 1 && c >= 1) begin
      run[n] = flag_item(r - 1, c - 1, window_differs(1, rows_ok, cols_ok), 1'b0, 1'b0);
      n++;
    end
    // row end: the last column's flag is ready too
    if (r >= 1 && c == w - 1) begin
      run[n] = flag_item(r - 1, c, window_differs(2, rows_ok, cols_ok), 1'b0, 1'b0);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) run[i].last = 1'b1;
      expected_flags.push_back(run[i]);
    end
    if (c + 1 < w) begin
      c++;
    end else begin
      c = 0;
      if (r + 1 < h) begin
        r++;
      end else begin
        r         = 0;
        draining  = 1'b1;
        drain_col = 0;
      end
    end
    in_row = r;
    in_col = c;
  endfunction

  // Flush transfer: flag one pixel of the last row from the line stores
  function automatic void push_flush_flag();
    int unsigned     w;
    int unsigned     h;
    int unsigned     k;
    int              col;
    bit [HASH_W-1:0] center;
    bit              flag;
    if (!draining) return;
    w    = clamp_size(width_reg, MAX_W);
    h    = clamp_size(height_reg, MAX_H);
    k    = drain_col;
    flag = 1'b0;
    if (k >= w) k = w - 1;
    center = middle_row_hash[k];
    for (int dc = -1; dc <= 1; dc++) begin
      col = int'(k) + dc;
      if (col < 0 || col >= int'(w)) continue;
      if (dc != 0 && middle_row_hash[col] != center) flag = 1'b1;
      if (h >= 2 && upper_row_hash[col] != center) flag = 1'b1;
    end
    expected_flags.push_back(flag_item(h - 1, k, flag, 1'b1, k == w - 1));
    if (k + 1 < w) begin
      drain_col = k + 1;
    end else begin
      drain_col = 0;
      draining  = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Result checker: every result transfer against the oldest expected flag
  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_flags.size() == 0) begin
        report_mismatch($sformatf("unexpected result for (%0d,%0d)",
                                  res_if.pixel_row, res_if.pixel_column));
      end else begin
        want = expected_flags.pop_front();
        if (res_if.pixel_row !== want.row)
          report_mismatch($sformatf("pixel_row: expected %0d, got %0d",
                                    want.row, res_if.pixel_row));
        if (res_if.pixel_column !== want.col)
          report_mismatch($sformatf("pixel_column: expected %0d, got %0d",
                                    want.col, res_if.pixel_column));
        if (res_if.needs_resample !== want.flag)
          report_mismatch($sformatf("needs_resample at (%0d,%0d): expected %0d, got %0b",
                                    want.row, want.col, want.flag, res_if.needs_resample));
        if (res_if.last_in_run !== want.last)
          report_mismatch($sformatf("last_in_run at (%0d,%0d): expected %0d, got %0b",
                                    want.row, want.col, want.last, res_if.last_in_run));
        if (res_if.frame_done !== want.done)
          report_mismatch($sformatf("frame_done at (%0d,%0d): expected %0d, got %0b",
                                    want.row, want.col, want.done, res_if.frame_done));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) res_if.ready <= ($urandom_range(99) >= stall_pct);

  // One input transfer; returns at a falling edge with valid still asserted
  task automatic send_item(op_e op, logic [HASH_W-1:0] hash);
    while ($urandom_range(99) < send_gap_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid      <= 1'b1;
    pix_if.operation  <= op;
    pix_if.hash_value <= hash;
    do @(posedge clk_i); while (!pix_if.ready);
    if (op == OP_FLUSH) push_flush_flag();
    else push_pixel_flags(hash);
    @(negedge clk_i);
  endtask

  // Quiesce input, let all expected results drain, then allow for in-flight work
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (expected_flags.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    load_size_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_frame_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // Whole frame (pixels then flushes) from a fresh palette; stops early at cut_at.
  // Noise items (flush mid-frame, pixel mid-drain) are ignored by the block.
  task automatic stream_frame(int unsigned cut_at, int unsigned noise_pct,
                              output int unsigned sent);
    int unsigned     w;
    int unsigned     h;
    int unsigned     pixels;
    int unsigned     pal_n;
    logic [HASH_W-1:0] hash;
    w      = clamp_size(width_reg, MAX_W);
    h      = clamp_size(height_reg, MAX_H);
    pixels = w * h;
    pal_n  = $urandom_range(1, 4);
    sent   = 0;
    for (int i = 0; i < 4; i++) palette[i] = {$urandom, $urandom};
    for (int unsigned idx = 0; idx < pixels + w && idx < cut_at; idx++) begin
      if ($urandom_range(99) < noise_pct) begin
        if (idx < pixels) send_item(OP_FLUSH, {$urandom, $urandom});
        else send_item(OP_PIXEL, {$urandom, $urandom});
      end
      if (idx < pixels) begin
        hash = ($urandom_range(3) != 0) ? palette[0] : palette[$urandom_range(pal_n - 1)];
        send_item(OP_PIXEL, hash);
      end else begin
        send_item(OP_FLUSH, {$urandom, $urandom});
      end
      sent++;
    end
  endtask

  // Reset size 640x480: part of row 1, then a size write drops the partial frame
  task automatic test_reset_size_restart();
    int unsigned n;
    palette[0] = {$urandom, $urandom};
    palette[1] = {$urandom, $urandom};
    for (int i = 0; i < 660; i++) send_item(OP_PIXEL, palette[$urandom_range(1)]);
    set_frame_size(12'd5, 12'd3);
    stream_frame(NO_CUT, 0, n);
  endtask

  // 3x3 frames: isolated center, extreme hashes, ignored flush and pixel
  task automatic test_small_patterns();
    set_frame_size(12'd3, 12'd3);
    send_item(OP_FLUSH, '1);
    for (int i = 0; i < 9; i++) send_item(OP_PIXEL, (i == 4) ? '1 : '0);
    send_item(OP_PIXEL, '1);
    repeat (3) send_item(OP_FLUSH, '0);
    // uniform frame right after: no pixel should be flagged
    for (int i = 0; i < 9; i++) send_item(OP_PIXEL, '1);
    repeat (3) send_item(OP_FLUSH, '1);
  endtask

  // Zero sizes clamp to a one-pixel frame; one-row and one-column frames
  task automatic test_size_extremes();
    int unsigned n;
    set_frame_size(12'd0, 12'd0);
    send_item(OP_PIXEL, {$urandom, $urandom});
    send_item(OP_PIXEL, {$urandom, $urandom});
    send_item(OP_FLUSH, '0);
    set_frame_size(12'd7, 12'd1);
    stream_frame(NO_CUT, 0, n);
    set_frame_size(12'd1, 12'd6);
    stream_frame(NO_CUT, 0, n);
  endtask

  // Write to an unmapped index mid-frame: the frame carries on
  task automatic test_unmapped_index();
    int unsigned n;
    set_frame_size(12'd4, 12'd3);
    stream_frame(6, 0, n);
    write_reg(CFG_UNMAPPED, 12'hFFF);
    for (int i = 0; i < 10; i++) begin
      if (i < 6) send_item(OP_PIXEL, palette[$urandom_range(1)]);
      else send_item(OP_FLUSH, palette[$urandom_range(1)]);
    end
  endtask

  // Random frame sizes and content, some frames cut short and restarted
  task automatic test_random_frames(int unsigned target);
    int unsigned sent;
    int unsigned n;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    int unsigned cut;
    bit          must_resize;
    sent        = 0;
    must_resize = 1'b1;
    while (sent < target) begin
      if (must_resize || $urandom_range(99) < 60) begin
        pick = $urandom_range(99);
        w = (pick < 70) ? $urandom_range(1, 6) :
            (pick < 95) ? $urandom_range(7, 40) : $urandom_range(41, 200);
        h = ($urandom_range(9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        set_frame_size((w == 1 && $urandom_range(1) == 1) ? 12'd0 : w[SIZE_W-1:0],
                       (h == 1 && $urandom_range(1) == 1) ? 12'd0 : h[SIZE_W-1:0]);
      end
      w   = clamp_size(width_reg, MAX_W);
      h   = clamp_size(height_reg, MAX_H);
      cut = ($urandom_range(99) < 15) ? $urandom_range(w * h + w - 1) : NO_CUT;
      must_resize = (cut != NO_CUT);
      stream_frame(cut, 5, n);
      sent += n;
    end
  endtask

  // Test sequence
  initial begin
    pix_if.valid      = 1'b0;
    pix_if.operation  = OP_PIXEL;
    pix_if.hash_value = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_FRAME_WIDTH;
    cfg_if.wdata      = '0;
    res_if.ready      = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_size_restart();
    test_small_patterns();
    test_size_extremes();
    test_unmapped_index();
    for (int phase = 0; phase < 4; phase++) begin
      send_gap_pct = gap_by_phase[phase];
      stall_pct    = stall_by_phase[phase];
      test_random_frames(RANDOM_ITEMS / 4);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("neighbor_difference_detector regression: pass");
    end else begin
      $display("neighbor_difference_detector regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("neighbor_difference_detector regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/ndd_pkg.sv
rtl/ndd_if.sv
rtl/ndd_res_fifo.sv
rtl/neighbor_difference_detector.sv
tb/sv/neighbor_difference_detector_tb.sv
